// ----- sv/assert_macros.svh -----
// Assertion macros used by the parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset
`define FJLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true out of reset
`define FJLP_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FJLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FJLP_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- sv/fjlp_pkg.sv -----
// Shared types, codes and helpers of the flat JSON line parser
package fjlp_pkg;

    // Result tags
    typedef enum logic [2:0] {
        TAG_KEY_BYTE = 3'd0,
        TAG_VAL_BYTE = 3'd1,
        TAG_KEY_END  = 3'd2,
        TAG_VAL_END  = 3'd3,
        TAG_DONE     = 3'd4,
        TAG_ERROR    = 3'd5
    } t_tag;

    // Error codes
    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_BRACE    = 4'd1,
        ERR_STRING   = 4'd2,
        ERR_ESCAPE   = 4'd3,
        ERR_HEX      = 4'd4,
        ERR_UNK_ESC  = 4'd5,
        ERR_UNTERM   = 4'd6,
        ERR_VALUE    = 4'd7,
        ERR_NESTED   = 4'd8,
        ERR_COLON    = 4'd9,
        ERR_COMMA    = 4'd10,
        ERR_TRAILING = 4'd11
    } t_err;

    localparam int unsigned MaxResults = 3;

    typedef struct packed {
        t_tag       tag;
        logic [7:0] out_byte;
        logic       quoted;
        t_err       code;
    } t_res;

    // Results of one input word, in order; cnt is how many are live
    typedef struct packed {
        logic [1:0]                 cnt;
        t_res [MaxResults-1:0]      res;
    } t_set;

    function automatic t_res mk_res(t_tag tag, logic [7:0] b, logic q, t_err code);
        t_res r;
        r.tag      = tag;
        r.out_byte = b;
        r.quoted   = q;
        r.code     = code;
        return r;
    endfunction

endpackage

// ----- sv/fjlp_in_if.sv -----
// Input channel: one line byte or an end-of-line mark per word
interface fjlp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

// ----- sv/fjlp_out_if.sv -----
// Output channel: one parser result per word
interface fjlp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] tag;
    logic [7:0] out_byte;
    logic       quoted;
    logic [3:0] code;
    logic       last;

    modport source (output valid, output tag, output out_byte, output quoted,
                    output code, output last, input ready);
    modport sink   (input valid, input tag, input out_byte, input quoted,
                    input code, input last, output ready);
endinterface

// ----- sv/fjlp_decode.sv -----
// Input register, parser state and the single-pass decode of one word
module fjlp_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fjlp_in_if.sink        i_in,
    input  logic           i_take,
    output fjlp_pkg::t_set o_set,
    output logic           o_set_valid
);

    typedef enum logic [9:0] {
        PH_START   = 10'b00_0000_0001,
        PH_OPEN    = 10'b00_0000_0010,
        PH_KEYWAIT = 10'b00_0000_0100,
        PH_STR     = 10'b00_0000_1000,
        PH_ESC     = 10'b00_0001_0000,
        PH_HEX     = 10'b00_0010_0000,
        PH_COLON   = 10'b00_0100_0000,
        PH_VALUE   = 10'b00_1000_0000,
        PH_AFTER   = 10'b01_0000_0000,
        PH_CLOSED  = 10'b10_0000_0000
    } t_phase;

    localparam logic [7:0] ChLBrace = 8'h7B;
    localparam logic [7:0] ChRBrace = 8'h7D;
    localparam logic [7:0] ChLBrack = 8'h5B;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChU      = 8'h75;

    function automatic logic is_ws(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

    logic         r_in_valid;
    logic         r_kind;
    logic [7:0]   r_byte;

    t_phase       r_phase, n_phase;
    logic [11:0]  r_hex, n_hex;
    logic [1:0]   r_digits, n_digits;
    logic         r_in_key, n_in_key;
    logic         r_failed, n_failed;
    logic         r_tok, n_tok;

    fjlp_pkg::t_set n_set;
    fjlp_pkg::t_tag w_str_tag;
    logic [4:0]     w_hex;
    logic [15:0]    w_cp;
    logic           w_adv;

    assign w_adv       = r_in_valid && i_take;
    assign i_in.ready  = !r_in_valid || i_take;
    assign o_set_valid = r_in_valid;
    assign o_set       = n_set;

    assign w_str_tag = r_in_key ? fjlp_pkg::TAG_KEY_BYTE : fjlp_pkg::TAG_VAL_BYTE;
    assign w_hex     = hex_digit(r_byte);
    assign w_cp      = {r_hex, w_hex[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_hex    <= '0;
            r_digits <= '0;
            r_in_key <= 1'b0;
            r_failed <= 1'b0;
            r_tok    <= 1'b0;
        end else if (w_adv) begin
            r_phase  <= n_phase;
            r_hex    <= n_hex;
            r_digits <= n_digits;
            r_in_key <= n_in_key;
            r_failed <= n_failed;
            r_tok    <= n_tok;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_hex    = r_hex;
        n_digits = r_digits;
        n_in_key = r_in_key;
        n_failed = r_failed;
        n_tok    = r_tok;
        n_set    = '0;

        if (r_kind) begin
            // End of line: report the outcome unless already failed, then restart
            if (!r_failed) begin
                n_set.cnt = 2'd1;
                unique case (r_phase)
                    PH_START: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_BRACE);
                    end
                    PH_OPEN, PH_KEYWAIT: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_STRING);
                    end
                    PH_STR: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_UNTERM);
                    end
                    PH_ESC: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_ESCAPE);
                    end
                    PH_HEX: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_HEX);
                    end
                    PH_COLON: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_COLON);
                    end
                    PH_VALUE: begin
                        if (r_tok) begin
                            n_set.cnt    = 2'd2;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_VAL_END, 8'h00,
                                                            1'b0, fjlp_pkg::ERR_NONE);
                            n_set.res[1] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00,
                                                            1'b0, fjlp_pkg::ERR_COMMA);
                        end else begin
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00,
                                                            1'b0, fjlp_pkg::ERR_VALUE);
                        end
                    end
                    PH_AFTER: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_COMMA);
                    end
                    PH_CLOSED: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_DONE, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_NONE);
                    end
                    default: begin
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_BRACE);
                    end
                endcase
            end
            n_phase  = PH_START;
            n_hex    = '0;
            n_digits = '0;
            n_in_key = 1'b0;
            n_failed = 1'b0;
            n_tok    = 1'b0;
        end else if (!r_failed) begin
            unique case (r_phase)
                PH_START: begin
                    if (!is_ws(r_byte)) begin
                        if (r_byte == ChLBrace) begin
                            n_phase = PH_OPEN;
                        end else begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_BRACE);
                            n_failed     = 1'b1;
                        end
                    end
                end
                PH_OPEN, PH_KEYWAIT: begin
                    if (!is_ws(r_byte)) begin
                        if (r_phase == PH_OPEN && r_byte == ChRBrace) begin
                            n_phase = PH_CLOSED;
                        end else if (r_byte == ChQuote) begin
                            n_in_key = 1'b1;
                            n_phase  = PH_STR;
                        end else begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_STRING);
                            n_failed     = 1'b1;
                        end
                    end
                end
                PH_STR: begin
                    if (r_byte == ChQuote) begin
                        n_set.cnt = 2'd1;
                        if (r_in_key) begin
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_KEY_END, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                            n_phase      = PH_COLON;
                        end else begin
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_VAL_END, 8'h00, 1'b1,
                                                            fjlp_pkg::ERR_NONE);
                            n_phase      = PH_AFTER;
                        end
                        n_in_key = 1'b0;
                    end else if (r_byte == ChBslash) begin
                        n_phase = PH_ESC;
                    end else begin
                        n_set.cnt    = 2'd1;
                        n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, r_byte, 1'b0,
                                                        fjlp_pkg::ERR_NONE);
                    end
                end
                PH_ESC: begin
                    n_phase   = PH_STR;
                    n_set.cnt = 2'd1;
                    unique case (r_byte)
                        ChQuote, ChBslash, ChSlash: begin
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, r_byte, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end
                        ChB: begin
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, 8'h08, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end
                        ChF: begin
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, 8'h0C, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end
                        ChN: begin
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, 8'h0A, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end
                        ChR: begin
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, 8'h0D, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end
                        ChT: begin
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, 8'h09, 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end
                        ChU: begin
                            n_set.cnt = 2'd0;
                            n_hex     = '0;
                            n_digits  = '0;
                            n_phase   = PH_HEX;
                        end
                        default: begin
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_UNK_ESC);
                            n_failed     = 1'b1;
                        end
                    endcase
                end
                PH_HEX: begin
                    if (!w_hex[4]) begin
                        n_set.cnt    = 2'd1;
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_HEX);
                        n_failed     = 1'b1;
                    end else if (r_digits == 2'd3) begin
                        // Fourth digit: encode the code point as UTF-8
                        if (w_cp < 16'h0080) begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, w_cp[7:0], 1'b0,
                                                            fjlp_pkg::ERR_NONE);
                        end else if (w_cp < 16'h0800) begin
                            n_set.cnt    = 2'd2;
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, {3'b110, w_cp[10:6]},
                                                            1'b0, fjlp_pkg::ERR_NONE);
                            n_set.res[1] = fjlp_pkg::mk_res(w_str_tag, {2'b10, w_cp[5:0]},
                                                            1'b0, fjlp_pkg::ERR_NONE);
                        end else begin
                            n_set.cnt    = 2'd3;
                            n_set.res[0] = fjlp_pkg::mk_res(w_str_tag, {4'b1110, w_cp[15:12]},
                                                            1'b0, fjlp_pkg::ERR_NONE);
                            n_set.res[1] = fjlp_pkg::mk_res(w_str_tag, {2'b10, w_cp[11:6]},
                                                            1'b0, fjlp_pkg::ERR_NONE);
                            n_set.res[2] = fjlp_pkg::mk_res(w_str_tag, {2'b10, w_cp[5:0]},
                                                            1'b0, fjlp_pkg::ERR_NONE);
                        end
                        n_hex    = '0;
                        n_digits = '0;
                        n_phase  = PH_STR;
                    end else begin
                        n_hex    = {r_hex[7:0], w_hex[3:0]};
                        n_digits = r_digits + 2'd1;
                    end
                end
                PH_COLON: begin
                    if (!is_ws(r_byte)) begin
                        if (r_byte == ChColon) begin
                            n_phase = PH_VALUE;
                            n_tok   = 1'b0;
                        end else begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_COLON);
                            n_failed     = 1'b1;
                        end
                    end
                end
                PH_VALUE: begin
                    if (!r_tok) begin
                        if (is_ws(r_byte)) begin
                            n_phase = PH_VALUE;
                        end else if (r_byte == ChQuote) begin
                            n_in_key = 1'b0;
                            n_phase  = PH_STR;
                        end else if (r_byte == ChComma || r_byte == ChRBrace) begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_VALUE);
                            n_failed     = 1'b1;
                        end else if (r_byte == ChLBrace || r_byte == ChLBrack) begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_NESTED);
                            n_failed     = 1'b1;
                        end else begin
                            n_tok        = 1'b1;
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_VAL_BYTE, r_byte,
                                                            1'b0, fjlp_pkg::ERR_NONE);
                        end
                    end else if (r_byte == ChComma || r_byte == ChRBrace || is_ws(r_byte)) begin
                        // Bare token ends; the delimiter takes effect at once
                        n_set.cnt    = 2'd1;
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_VAL_END, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_NONE);
                        n_tok        = 1'b0;
                        if (r_byte == ChComma) begin
                            n_phase = PH_KEYWAIT;
                        end else if (r_byte == ChRBrace) begin
                            n_phase = PH_CLOSED;
                        end else begin
                            n_phase = PH_AFTER;
                        end
                    end else begin
                        n_set.cnt    = 2'd1;
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_VAL_BYTE, r_byte, 1'b0,
                                                        fjlp_pkg::ERR_NONE);
                    end
                end
                PH_AFTER: begin
                    if (!is_ws(r_byte)) begin
                        if (r_byte == ChComma) begin
                            n_phase = PH_KEYWAIT;
                        end else if (r_byte == ChRBrace) begin
                            n_phase = PH_CLOSED;
                        end else begin
                            n_set.cnt    = 2'd1;
                            n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                            fjlp_pkg::ERR_COMMA);
                            n_failed     = 1'b1;
                        end
                    end
                end
                PH_CLOSED: begin
                    if (!is_ws(r_byte)) begin
                        n_set.cnt    = 2'd1;
                        n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                        fjlp_pkg::ERR_TRAILING);
                        n_failed     = 1'b1;
                    end
                end
                default: begin
                    n_set.cnt    = 2'd1;
                    n_set.res[0] = fjlp_pkg::mk_res(fjlp_pkg::TAG_ERROR, 8'h00, 1'b0,
                                                    fjlp_pkg::ERR_BRACE);
                    n_failed     = 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- sv/fjlp_outq.sv -----
// Result register: holds one word's results and hands them out one at a time
`include "assert_macros.svh"

module fjlp_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fjlp_pkg::t_set i_set,
    input  logic           i_set_valid,
    output logic           o_take,
    fjlp_out_if.source     o_res
);

    fjlp_pkg::t_res [fjlp_pkg::MaxResults-1:0] r_res;
    logic [1:0]     r_cnt;
    logic [1:0]     r_idx;
    logic           r_valid;

    fjlp_pkg::t_res w_cur;
    logic           w_is_last;
    logic           w_last_out;
    logic           w_load;

    assign w_cur      = r_res[r_idx];
    assign w_is_last  = (r_idx == r_cnt - 2'd1);
    assign w_last_out = r_valid && o_res.ready && w_is_last;
    assign o_take     = !r_valid || w_last_out;
    // Words that cause no result are dropped here
    assign w_load     = i_set_valid && o_take && (i_set.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_last_out) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (r_valid && o_res.ready) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_set.res;
            r_cnt <= i_set.cnt;
        end
    end

    assign o_res.valid    = r_valid;
    assign o_res.tag      = w_cur.tag;
    assign o_res.out_byte = w_cur.out_byte;
    assign o_res.quoted   = w_cur.quoted;
    assign o_res.code     = w_cur.code;
    assign o_res.last     = w_is_last;

    `FJLP_NEVER(a_cnt_nonzero, i_clk, i_rst_n, r_valid && r_cnt == 2'd0, "empty result set held")
    `FJLP_NEVER(a_idx_in_range, i_clk, i_rst_n, r_valid && r_idx >= r_cnt, "result index overrun")
    `FJLP_ASSERT(a_stall_holds, i_clk, i_rst_n, r_valid && !o_res.ready |=> r_valid && $stable(r_idx), "stalled result moved")
    `FJLP_NEVER(a_no_overwrite, i_clk, i_rst_n, w_load && r_valid && !w_last_out, "result set overwritten")

endmodule

// ----- sv/flat_json_line_parser_unit.sv -----
// Top level of the flat JSON line parser
//
// Streams one text line per object of the form {"key":value,...}. Each word on
// i_in is either a line byte (kind = 0) or an end-of-line mark (kind = 1).
// Results leave on o_res: decoded key and value bytes with escapes undone
// (a \u escape gives one to three UTF-8 bytes), key-end and value-end marks,
// and a single done or error word closing each line. After an error, bytes
// are dropped without result until the end-of-line mark restarts the parser.
//
// A word accepted on i_in sits in the input register, is decoded in one pass
// and lands in the result register once that can take the whole set; its
// results are then offered from there. Throughput is one input word per cycle
// while each word causes at most one result and o_res is not stalled; a word
// with more results (a \u escape up to three, the end of a line inside a bare
// token two) holds the result register until its last result is taken; input
// ready stays low meanwhile once the next word waits in the input register.
//
// Reset (synchronous, active low) empties both registers and puts the parser
// back to waiting for the opening brace. When the receiver stalls, the current
// result holds and, once the input register is also full, i_in.ready falls.
module flat_json_line_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fjlp_in_if.sink    i_in,
    fjlp_out_if.source o_res
);

    fjlp_pkg::t_set w_set;
    logic           w_set_valid;
    logic           w_take;

    // Input register and the decode of one word against the parser state
    fjlp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_take      (w_take),
        .o_set       (w_set),
        .o_set_valid (w_set_valid)
    );

    // Result register; advances the decode only when it can take the whole set
    fjlp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set       (w_set),
        .i_set_valid (w_set_valid),
        .o_take      (w_take),
        .o_res       (o_res)
    );

endmodule
